// ===== design/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// Used by utf8d_decode, utf8d_out_reg and utf8_stream_decoder; no dependencies.
package utf8d_pkg;

    localparam int ByteW = 8;
    localparam int CpW   = 31;
    localparam int LenW  = 3;
    localparam int StW   = 2;

    // Payload bit width on the master side, padded to whole bytes.
    localparam int OutDataW = ((CpW + LenW + 7) / 8) * 8;

    // Continuation bytes carry six payload bits.
    localparam int ContBits = 6;

    localparam logic [ByteW-1:0] ContMask   = 8'hC0;
    localparam logic [ByteW-1:0] ContTag    = 8'h80;
    localparam logic [ByteW-1:0] ContData   = 8'h3F;
    localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Tag   = 8'hC0;
    localparam logic [ByteW-1:0] Lead2Data  = 8'h1F;
    localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Tag   = 8'hE0;
    localparam logic [ByteW-1:0] Lead3Data  = 8'h0F;
    localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
    localparam logic [ByteW-1:0] Lead4Tag   = 8'hF0;
    localparam logic [ByteW-1:0] Lead4Data  = 8'h07;
    localparam logic [ByteW-1:0] Lead5Mask  = 8'hFC;
    localparam logic [ByteW-1:0] Lead5Tag   = 8'hF8;
    localparam logic [ByteW-1:0] Lead5Data  = 8'h03;
    localparam logic [ByteW-1:0] Lead6Mask  = 8'hFE;
    localparam logic [ByteW-1:0] Lead6Tag   = 8'hFC;
    localparam logic [ByteW-1:0] Lead6Data  = 8'h01;

    typedef enum logic [StW-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2
    } status_t;

    typedef struct packed {
        logic [CpW-1:0]  char_code;
        logic [LenW-1:0] seq_length;
        status_t         status;
    } result_t;

endpackage

// ===== design/utf8d_decode.sv =====
// Sequence decoder: lead/continuation classification, accumulator and count state.
// Depends on utf8d_pkg.
module utf8d_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [utf8d_pkg::ByteW-1:0]   in_byte,
    input  logic                          consume,
    output logic                          res_valid,
    output utf8d_pkg::result_t            res
);

    logic [utf8d_pkg::CpW-1:0]  acc_reg, acc_next;
    logic [utf8d_pkg::LenW-1:0] rem_reg, rem_next;
    logic [utf8d_pkg::LenW-1:0] exp_reg, exp_next;

    logic                       take;
    logic                       is_cont;
    logic [utf8d_pkg::CpW-1:0]  acc_shift;

    assign take      = in_valid && consume;
    assign is_cont   = (in_byte & utf8d_pkg::ContMask) == utf8d_pkg::ContTag;
    assign acc_shift = {acc_reg[utf8d_pkg::CpW-utf8d_pkg::ContBits-1:0],
                        in_byte[utf8d_pkg::ContBits-1:0]};

    always_comb
    begin
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        exp_next       = exp_reg;
        res_valid      = 1'b0;
        res.char_code  = '0;
        res.seq_length = '0;
        res.status     = utf8d_pkg::ST_OK;

        if (rem_reg != '0)
        begin
            if (!is_cont)
            begin
                // abandon the sequence, byte is dropped
                res_valid  = in_valid;
                res.status = utf8d_pkg::ST_BAD_CONT;
                rem_next   = '0;
                exp_next   = '0;
                acc_next   = '0;
            end
            else if (rem_reg == 3'd1)
            begin
                res_valid      = in_valid;
                res.char_code  = acc_shift;
                res.seq_length = exp_reg;
                rem_next       = '0;
                exp_next       = '0;
                acc_next       = '0;
            end
            else
            begin
                acc_next = acc_shift;
                rem_next = rem_reg - 3'd1;
            end
        end
        else if (!in_byte[utf8d_pkg::ByteW-1])
        begin
            res_valid      = in_valid;
            res.char_code  = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, in_byte};
            res.seq_length = 3'd1;
        end
        else if ((in_byte & utf8d_pkg::Lead2Mask) == utf8d_pkg::Lead2Tag)
        begin
            acc_next = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                        in_byte & utf8d_pkg::Lead2Data};
            exp_next = 3'd2;
            rem_next = 3'd1;
        end
        else if ((in_byte & utf8d_pkg::Lead3Mask) == utf8d_pkg::Lead3Tag)
        begin
            acc_next = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                        in_byte & utf8d_pkg::Lead3Data};
            exp_next = 3'd3;
            rem_next = 3'd2;
        end
        else if ((in_byte & utf8d_pkg::Lead4Mask) == utf8d_pkg::Lead4Tag)
        begin
            acc_next = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                        in_byte & utf8d_pkg::Lead4Data};
            exp_next = 3'd4;
            rem_next = 3'd3;
        end
        else if ((in_byte & utf8d_pkg::Lead5Mask) == utf8d_pkg::Lead5Tag)
        begin
            acc_next = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                        in_byte & utf8d_pkg::Lead5Data};
            exp_next = 3'd5;
            rem_next = 3'd4;
        end
        else if ((in_byte & utf8d_pkg::Lead6Mask) == utf8d_pkg::Lead6Tag)
        begin
            acc_next = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                        in_byte & utf8d_pkg::Lead6Data};
            exp_next = 3'd6;
            rem_next = 3'd5;
        end
        else
        begin
            // stray continuation, 0xFE or 0xFF
            res_valid  = in_valid;
            res.status = utf8d_pkg::ST_BAD_LEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            exp_reg <= '0;
        end
        else if (take)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            exp_reg <= exp_next;
        end
    end

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd5)
        else $error("continuation count out of range");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid |=> rem_reg == '0)
        else $error("state not idle after a result");

    a_bad_cont_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == utf8d_pkg::ST_BAD_CONT |-> rem_reg != '0)
        else $error("bad continuation reported outside a sequence");

    a_multi_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == utf8d_pkg::ST_OK && res.seq_length > 3'd1
        |-> rem_reg == 3'd1 && exp_reg == res.seq_length)
        else $error("multibyte result not at last continuation");

endmodule

// ===== design/utf8d_out_reg.sv =====
// Result register between the decoder and the master-side stream.
// Depends on utf8d_pkg.
module utf8d_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  utf8d_pkg::result_t  in_res,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output utf8d_pkg::result_t  out_res
);

    logic               valid_reg, valid_next;
    utf8d_pkg::result_t res_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== design/utf8_stream_decoder.sv =====
// UTF-8 (six-byte form) stream decoder top level: input register, decoder, result register.
// Depends on utf8d_pkg, utf8d_decode and utf8d_out_reg.
//
// Usage:
//   Slave stream s_axis_* carries one raw byte per request in s_axis_tdata[7:0].
//   Master stream m_axis_* carries one result per completed or failed sequence:
//   tdata = char code [30:0], seq_length [33:31], zero pad [39:34];
//   tuser = status (0 ok, 1 invalid lead byte, 2 bad continuation byte).
//   Error results carry char code 0 and seq_length 0.
//   Bytes that only start or extend a sequence produce no result.
// Timing:
//   One byte per cycle sustained while m_axis_tready is high; each byte waits in
//   the input register, is decoded in the same cycle it leaves it, and its result
//   is registered in the result register for m_axis. The per-byte path is a chain
//   of mask/compares and a 6-bit shift into the accumulator.
// Reset:
//   rst_n clears the valid flags of both register stages and returns the decoder to idle.
// Stall:
//   With m_axis_tready low the result register holds; one more byte is still taken
//   into the input register, then s_axis_tready drops until the result is taken.
module utf8_stream_decoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] byte_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [30:0] char code, [33:31] seq_length, rest zero
    output logic [utf8d_pkg::OutDataW-1:0]    m_axis_tdata,
    output logic [utf8d_pkg::StW-1:0]         m_axis_tuser   // [1:0] status
);

    logic                          in_valid_reg, in_valid_next;
    logic [utf8d_pkg::ByteW-1:0]   in_byte_reg;

    logic                          dec_valid;
    utf8d_pkg::result_t            dec_res;
    logic                          out_ready;
    utf8d_pkg::result_t            out_res;

    // Input register drains whenever the result register can take a result.
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    utf8d_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .consume   (out_ready),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    utf8d_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_res    (dec_res),
        .in_ready  (out_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {{(utf8d_pkg::OutDataW-utf8d_pkg::CpW-utf8d_pkg::LenW){1'b0}},
                           out_res.seq_length, out_res.char_code};
    assign m_axis_tuser = out_res.status;

endmodule
